### hdl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                    command;
        logic signed [KEY_W-1:0] value;
    } spq_req_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] removed_value;
        logic [1:0]              status;
        logic [4:0]              occupancy;
    } spq_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;  // capture the request
        logic exec;  // apply it and fill the result register
    } spq_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } spq_state_t;

endpackage

### hdl/spq_ctrl.sv
`timescale 1ns / 1ps

module spq_ctrl
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output spq_ctrl_t ctrl
);

    spq_state_t state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       slot_free;

    // result register can take a new result this cycle
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        ctrl.exec = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
            end
            S_EXEC:
            begin
                ctrl.exec = slot_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
        ctrl.load = req_valid && req_ready;
    end

    always_comb
    begin
        if (ctrl.exec)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

### hdl/spq_datapath.sv
`timescale 1ns / 1ps

module spq_datapath
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  spq_ctrl_t ctrl,
    input  spq_req_t  req,
    output spq_rsp_t  rsp
);

    spq_req_t                req_reg;
    logic signed [KEY_W-1:0] entry_reg  [CAPACITY];
    logic signed [KEY_W-1:0] entry_next [CAPACITY];
    logic [CNT_W-1:0]        count_reg, count_next;
    spq_rsp_t                rsp_reg, rsp_next;
    logic [CAPACITY-1:0]     le;
    logic                    full, empty;

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    // per-slot compare: occupied and not greater than the new key
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            le[i] = (CNT_W'(i) < count_reg) && (entry_reg[i] <= req_reg.value);
    end

    always_comb
    begin
        count_next             = count_reg;
        rsp_next.removed_value = '0;
        rsp_next.status        = ST_OK;
        for (int i = 0; i < CAPACITY; i++)
            entry_next[i] = entry_reg[i];

        if (req_reg.command == CMD_INSERT)
        begin
            if (full)
                rsp_next.status = ST_FULL;
            else
            begin
                // slots ahead of the insert point hold, the rest move up one
                entry_next[0] = le[0] ? entry_reg[0] : req_reg.value;
                for (int i = 1; i < CAPACITY; i++)
                begin
                    if (le[i])
                        entry_next[i] = entry_reg[i];
                    else if (le[i-1])
                        entry_next[i] = req_reg.value;
                    else
                        entry_next[i] = entry_reg[i-1];
                end
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            if (empty)
                rsp_next.status = ST_EMPTY;
            else
            begin
                rsp_next.removed_value = entry_reg[0];
                for (int i = 0; i < CAPACITY - 1; i++)
                    entry_next[i] = entry_reg[i+1];
                count_next = count_reg - 1'b1;
            end
        end
        rsp_next.occupancy = 5'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            req_reg <= req;
        if (ctrl.exec)
        begin
            for (int i = 0; i < CAPACITY; i++)
                entry_reg[i] <= entry_next[i];
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ctrl.exec)
            count_reg <= count_next;
    end

    assign rsp = rsp_reg;

endmodule

### hdl/sorted_priority_queue.sv
`timescale 1ns / 1ps

// Sorted priority queue: a bounded min-priority queue of up to CAPACITY (16)
// signed 32-bit keys held in ascending order in a register chain. Each request
// is an insert (command 0) or a remove of the smallest key (command 1), and
// each gives exactly one response. Equal keys leave in arrival order. A remove
// on an empty queue answers status 1 with removed_value zero; an insert into a
// full queue is dropped with status 2. occupancy is the count after the
// operation. Both channels are valid/ready; a transfer happens when both are
// high. For each item the request is first captured; then, once the result
// register is free, every slot of the chain compares against the key in
// parallel and the chain and the result register update together. Requests
// are handled one at a time: no new request is taken until the previous one
// has executed, but the next request is captured while the previous
// response still waits in the output register. No clearing pass after reset.

module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  spq_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output spq_rsp_t rsp
);

    spq_ctrl_t ctrl;

    // sequencing: request capture, execute, response handshake
    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctrl      (ctrl)
    );

    // sorted register chain, count and result register
    spq_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

### hdl/spq_checker.sv
`timescale 1ns / 1ps

module spq_assertions
    import spq_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input spq_rsp_t rsp
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // one request in flight: no transfer in the cycle after one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.occupancy == '0 && rsp.removed_value == '0)
        else $error("empty status with entries or a value");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL
            |-> rsp.occupancy == 5'(CAPACITY) && rsp.removed_value == '0)
        else $error("full status with wrong occupancy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_EMPTY || rsp.status == ST_FULL)
        else $error("undefined status code");

endmodule

bind sorted_priority_queue spq_assertions u_spq_assertions (.*);
